/* design/sim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapped interval merger package
// Widths, register codes and word types shared by the merger modules.
// ----------------------------------------------------------------------------
package sim_pkg;

   localparam int TIME_BITS = 40;
   localparam int END_BITS  = TIME_BITS + 1;
   localparam int GRID_BITS = 21;

   // Width of the end-snapping sum: end plus an addend of up to 2^GRID_BITS.
   localparam int SUM_BITS  = ((TIME_BITS > GRID_BITS + 1) ? TIME_BITS : GRID_BITS + 1) + 1;

   // Iteration counter of the serial remainder unit, able to hold TIME_BITS.
   localparam int CNT_BITS  = $clog2(TIME_BITS + 1);

   localparam logic [GRID_BITS-1:0] GRID_RESET = GRID_BITS'(60);
   localparam logic [END_BITS-1:0]  END_MAX    = '1;

   // Configuration port: byte address bits and register index codes.
   localparam int   CSR_ADDR_BITS = 3;
   localparam int   CSR_DATA_BITS = 32;
   localparam logic REG_SNAP_GRID = 1'b0;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] end_time;
      logic                 last_in_list;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] merged_start;
      logic [END_BITS-1:0]  merged_end;
      logic                 ends_list;
      logic                 last_of_run;
   } rsp_type;

   // One snapped interval handed from the snapping stage to the merge stage.
   typedef struct packed {
      logic [TIME_BITS-1:0] snap_start;
      logic [END_BITS-1:0]  snap_end;
      logic                 last;
   } snap_type;

endpackage

/* design/sim_rem_serial.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one dividend bit per cycle; keeps only the remainder.
// ----------------------------------------------------------------------------
module sim_rem_serial (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [sim_pkg::TIME_BITS-1:0] dividend,
   input  logic [sim_pkg::GRID_BITS-1:0] divisor,
   output logic                          busy,
   output logic [sim_pkg::GRID_BITS-1:0] remainder
);

   logic [sim_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [sim_pkg::TIME_BITS-1:0] shift_ff, shift_in;
   logic [sim_pkg::GRID_BITS-1:0] rem_ff, rem_in;
   logic [sim_pkg::GRID_BITS:0]   trial;

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[sim_pkg::TIME_BITS-1]};
      if (load) begin
         count_in = sim_pkg::CNT_BITS'(sim_pkg::TIME_BITS);
         shift_in = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[sim_pkg::TIME_BITS-2:0], 1'b0};
         // The trial stays below twice the divisor, so the difference fits.
         if (trial >= {1'b0, divisor}) begin
            rem_in = sim_pkg::GRID_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[sim_pkg::GRID_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

/* design/sim_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval merge stage
// Holds the open merged interval and a two-word result queue.
// ----------------------------------------------------------------------------
module sim_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              merge_valid,
   input  sim_pkg::snap_type merge_data,
   output logic              queue_empty,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sim_pkg::rsp_type  rsp_data
);

   logic                          open_valid_ff, open_valid_in;
   logic [sim_pkg::TIME_BITS-1:0] open_start_ff, open_start_in;
   logic [sim_pkg::END_BITS-1:0]  open_end_ff, open_end_in;
   sim_pkg::rsp_type              slot_ff [2];
   sim_pkg::rsp_type              slot_in [2];
   logic [1:0]                    count_ff, count_in;
   logic                          hit;
   logic                          brk;
   logic [sim_pkg::TIME_BITS-1:0] upd_start;
   logic [sim_pkg::END_BITS-1:0]  upd_end;
   sim_pkg::rsp_type              brk_word;
   sim_pkg::rsp_type              flush_word;

   always_comb begin
      hit = open_valid_ff && ({1'b0, merge_data.snap_start} <= open_end_ff);
      brk = open_valid_ff && !hit;

      if (hit) begin
         upd_start = open_start_ff;
         upd_end   = (merge_data.snap_end > open_end_ff) ? merge_data.snap_end : open_end_ff;
      end else begin
         upd_start = merge_data.snap_start;
         upd_end   = merge_data.snap_end;
      end

      brk_word.merged_start = open_start_ff;
      brk_word.merged_end   = open_end_ff;
      brk_word.ends_list    = 1'b0;
      brk_word.last_of_run  = !merge_data.last;

      flush_word.merged_start = upd_start;
      flush_word.merged_end   = upd_end;
      flush_word.ends_list    = 1'b1;
      flush_word.last_of_run  = 1'b1;

      open_valid_in = open_valid_ff;
      open_start_in = open_start_ff;
      open_end_in   = open_end_ff;
      slot_in[0]    = slot_ff[0];
      slot_in[1]    = slot_ff[1];
      count_in      = count_ff;

      // A merge is only issued into an empty queue, so it never meets a pop.
      if (merge_valid) begin
         if (merge_data.last) begin
            open_valid_in = 1'b0;
            open_start_in = '0;
            open_end_in   = '0;
         end else begin
            open_valid_in = 1'b1;
            open_start_in = upd_start;
            open_end_in   = upd_end;
         end
         if (brk) begin
            slot_in[0] = brk_word;
            slot_in[1] = flush_word;
         end else begin
            slot_in[0] = flush_word;
         end
         count_in = {1'b0, brk} + {1'b0, merge_data.last};
      end else if (rsp_valid && rsp_ready) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_valid_ff <= 1'b0;
         open_start_ff <= '0;
         open_end_ff   <= '0;
         count_ff      <= '0;
      end else begin
         open_valid_ff <= open_valid_in;
         open_start_ff <= open_start_in;
         open_end_ff   <= open_end_in;
         count_ff      <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign queue_empty = (count_ff == '0);
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = slot_ff[0];

endmodule

/* design/snapped_interval_merger.sv */
`timescale 1ns / 1ps
// Each accepted word passes the divide, snap and merge states; the merge waits for an empty
// result queue. A new word is taken only in idle, after the last one has merged. The remainder
// units take one dividend bit per cycle; result words drain while the next word divides.
// Reset (synchronous, active high): no open interval, empty result queue, snap_grid = 60.
// ----------------------------------------------------------------------------
// Snapped interval merger
// Snaps interval starts down and ends up to a grid, then merges overlapping
// intervals of a sorted list into one open interval that is emitted on a break
// or at the end of the list.
// ----------------------------------------------------------------------------
module snapped_interval_merger (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sim_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sim_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sim_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [sim_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [sim_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);

   // The sequencer steps through accept, divide, snap and merge. Each state
   // is one bit of the code so that a decode is a single flop.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SNAP   = 4'b0100,
      ST_MERGE  = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [sim_pkg::GRID_BITS-1:0] snap_grid_ff, snap_grid_in;
   logic [sim_pkg::GRID_BITS-1:0] grid_ff;
   logic [sim_pkg::TIME_BITS-1:0] start_hold_ff;
   logic [sim_pkg::TIME_BITS-1:0] end_hold_ff;
   logic                          last_hold_ff;
   sim_pkg::snap_type             snap_ff, snap_in;

   logic                          req_fire;
   logic                          csr_write;
   logic                          div_busy_s;
   logic                          div_busy_e;
   logic [sim_pkg::GRID_BITS-1:0] rem_s;
   logic [sim_pkg::GRID_BITS-1:0] rem_e;
   logic [sim_pkg::GRID_BITS:0]   end_add;
   logic [sim_pkg::SUM_BITS-1:0]  end_sum;
   logic                          merge_fire;
   logic                          queue_empty;

   // ------------------------------------------------------------------
   // Configuration port. The register index is the word address bit, so
   // a write to any other word is dropped. pready is tied high.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == sim_pkg::REG_SNAP_GRID);

   always_comb begin
      snap_grid_in = snap_grid_ff;
      if (csr_write) begin
         snap_grid_in = pwdata[sim_pkg::GRID_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == sim_pkg::REG_SNAP_GRID) begin
         prdata = sim_pkg::CSR_DATA_BITS'(snap_grid_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer. A new word is taken only in idle; the result queue keeps
   // draining while the next word divides.
   // ------------------------------------------------------------------
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign merge_fire = (state_ff == ST_MERGE) && queue_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy_s) begin
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (queue_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         snap_grid_ff <= sim_pkg::GRID_RESET;
      end else begin
         state_ff     <= state_in;
         snap_grid_ff <= snap_grid_in;
      end
   end

   // The word and the grid are captured at accept. A zero grid acts as one,
   // which leaves the times unsnapped.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_hold_ff <= req_data.start_time;
         end_hold_ff   <= req_data.end_time;
         last_hold_ff  <= req_data.last_in_list;
         grid_ff       <= (snap_grid_ff == '0) ? sim_pkg::GRID_BITS'(1) : snap_grid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Two bit-serial remainder units, one for the start and one for the end.
   // They are loaded together and finish together.
   // ------------------------------------------------------------------
   sim_rem_serial u_rem_start (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .dividend  (req_data.start_time),
      .divisor   (grid_ff),
      .busy      (div_busy_s),
      .remainder (rem_s)
   );

   sim_rem_serial u_rem_end (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .dividend  (req_data.end_time),
      .divisor   (grid_ff),
      .busy      (div_busy_e),
      .remainder (rem_e)
   );

   // ------------------------------------------------------------------
   // Snapping. The start drops its remainder. The end rises by the gap to
   // the next grid line and saturates at the largest merged end.
   // ------------------------------------------------------------------
   always_comb begin
      end_add = {1'b0, grid_ff} - {1'b0, rem_e};
      end_sum = sim_pkg::SUM_BITS'(end_hold_ff) + sim_pkg::SUM_BITS'(end_add);

      snap_in            = snap_ff;
      if (state_ff == ST_SNAP) begin
         snap_in.snap_start = start_hold_ff - sim_pkg::TIME_BITS'(rem_s);
         snap_in.last       = last_hold_ff;
         if (rem_e == '0) begin
            snap_in.snap_end = sim_pkg::END_BITS'(end_hold_ff);
         end else if (end_sum > sim_pkg::SUM_BITS'(sim_pkg::END_MAX)) begin
            snap_in.snap_end = sim_pkg::END_MAX;
         end else begin
            snap_in.snap_end = end_sum[sim_pkg::END_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   // ------------------------------------------------------------------
   // Merge stage and result queue.
   // ------------------------------------------------------------------
   sim_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .merge_valid (merge_fire),
      .merge_data  (snap_ff),
      .queue_empty (queue_empty),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The two remainder units are loaded together and must stay in step.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_busy_s == div_busy_e)
      else $error("remainder units out of step");

   // An accepted word starts both remainder units and the divide state.
   a_accept_divides: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_DIVIDE) && div_busy_s)
      else $error("accepted word did not start the divide");

   // Snapping reads the remainders only once the division is complete.
   a_snap_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SNAP) |-> !div_busy_s && !div_busy_e)
      else $error("snap while the remainder units are still busy");

   // A merge of a list's final word writes into an empty queue, so a word is pending right after it.
   a_merge_queue: assert property (@(posedge clock) disable iff (reset)
      merge_fire && snap_ff.last |=> rsp_valid)
      else $error("end of list produced no result word");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapped interval merger testbench
// Drives interval words through the merger under directed and random lists,
// several grid settings and random idling on both sides. A scoreboard predicts
// each merged interval, and a monitor compares every result word against it.
// ----------------------------------------------------------------------------
module tb_top;

   // Settle for longer than one word takes through the merger before the grid
   // register is touched or the run is closed.
   localparam int SETTLE_CYCLES = sim_pkg::TIME_BITS + 16;
   localparam int HOLD_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_WORDS   = 375;
   localparam logic [sim_pkg::CSR_ADDR_BITS-1:0] GRID_ADDR =
      sim_pkg::CSR_ADDR_BITS'(4 * sim_pkg::REG_SNAP_GRID);
   localparam logic [sim_pkg::TIME_BITS-1:0]     TIME_TOP  = '1;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   sim_pkg::req_type                  req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   sim_pkg::rsp_type                  rsp_data;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [sim_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [sim_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [sim_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   // Scoreboard state: a private copy of the grid and of the open interval.
   logic [sim_pkg::GRID_BITS-1:0]     track_grid = sim_pkg::GRID_RESET;
   logic                              track_open = 1'b0;
   logic [sim_pkg::TIME_BITS-1:0]     track_start = '0;
   logic [sim_pkg::END_BITS-1:0]      track_end = '0;
   sim_pkg::rsp_type                  pending_merges[$];

   int unsigned                       send_idle_pct = 0;
   int unsigned                       rsp_stall_pct = 0;
   int unsigned                       words_sent = 0;
   int unsigned                       error_count = 0;
   int unsigned                       cycle_count = 0;
   logic                              hold_request = 1'b0;
   logic                              hold_on = 1'b0;

   snapped_interval_merger DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog. The slowest legal run is far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The receiver stalls at random, and drops ready entirely while a long
   // hold-off is running so that the merger backs up into its input.
   always @(posedge clock) begin
      rsp_ready <= !hold_on && ($urandom_range(99) >= rsp_stall_pct);
   end

   // The hold-off counts its own cycles once a test asks for it.
   always begin
      wait (hold_request);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
      hold_request = 1'b0;
   end

   // Only the first ten problems are printed; the rest are just counted.
   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("tb: mismatch: %s", what);
   endtask

   // Appends one predicted result word to the back of the expected queue.
   function automatic void book_word(input sim_pkg::rsp_type word);
      pending_merges.insert(pending_merges.size(), word);
   endfunction

   // Scoreboard step for one accepted word. Starts snap down and ends snap up
   // to the grid, a grid of zero behaves as a grid of one, and snapped ends
   // clamp at the top of the merged end range.
   function automatic void merge_interval(input sim_pkg::req_type w);
      logic [63:0]      step;
      logic [63:0]      low;
      logic [63:0]      high;
      logic [63:0]      rem;
      logic [63:0]      pad;
      logic [63:0]      top;
      sim_pkg::rsp_type word;
      begin
         top  = 64'(sim_pkg::END_MAX);
         step = (track_grid == '0) ? 64'd1 : 64'(track_grid);
         low  = 64'(w.start_time);
         low  = low - (low % step);
         high = 64'(w.end_time);
         rem  = high % step;
         if (rem != 0) begin
            pad = step - rem;
            high = (high > top - pad) ? top : high + pad;
         end

         if (track_open && low <= 64'(track_end)) begin
            // Overlap is judged against the merged end, so an unsorted start
            // still joins the open interval and leaves its start alone.
            if (high > 64'(track_end))
               track_end = sim_pkg::END_BITS'(high);
         end else begin
            if (track_open) begin
               word.merged_start = track_start;
               word.merged_end   = track_end;
               word.ends_list    = 1'b0;
               word.last_of_run  = !w.last_in_list;
               book_word(word);
            end
            track_open  = 1'b1;
            track_start = sim_pkg::TIME_BITS'(low);
            track_end   = sim_pkg::END_BITS'(high);
         end

         // The final word of a list flushes whatever is open.
         if (w.last_in_list) begin
            word.merged_start = track_start;
            word.merged_end   = track_end;
            word.ends_list    = 1'b1;
            word.last_of_run  = 1'b1;
            book_word(word);
            track_open  = 1'b0;
            track_start = '0;
            track_end   = '0;
         end
      end
   endfunction

   // Offers one word, after a random idle stretch, and books its prediction
   // at the edge where it is taken. Valid is left high for the next caller.
   task automatic send_word(input sim_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      merge_interval(w);
      words_sent++;
   endtask

   // Waits for every predicted word, then for the divider to run dry too,
   // since a word that only opens or extends an interval shows no result.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_merges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the grid register, then reads it straight back. Psel stays high
   // from the write access into the read setup.
   task automatic program_grid(input logic [sim_pkg::CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= GRID_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      track_grid = value[sim_pkg::GRID_BITS-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[sim_pkg::GRID_BITS-1:0] !== track_grid)
         flag_error($sformatf("grid readback expected %0d got %0d", track_grid,
                              prdata[sim_pkg::GRID_BITS-1:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [sim_pkg::TIME_BITS-1:0] random_time();
      return sim_pkg::TIME_BITS'({$urandom, $urandom});
   endfunction

   task automatic send_interval(input logic [sim_pkg::TIME_BITS-1:0] from,
                                input logic [sim_pkg::TIME_BITS-1:0] upto,
                                input logic last);
      sim_pkg::req_type w;
      w.start_time   = from;
      w.end_time     = upto;
      w.last_in_list = last;
      send_word(w);
   endtask

   // One sorted list with random spacing around the grid step, so that both
   // merges and breaks happen. Some lists are cut off without a final word,
   // and now and then an interval ends before it starts.
   task automatic send_random_list(input logic cut_short);
      int unsigned                   count;
      int unsigned                   step;
      logic [sim_pkg::TIME_BITS-1:0] at;
      logic [sim_pkg::TIME_BITS-1:0] upto;
      begin
         step  = (track_grid == '0) ? 1 : int'(track_grid);
         count = $urandom_range(1, 8);
         at    = random_time();
         if ($urandom_range(1) == 0)
            at = at >> $urandom_range(sim_pkg::TIME_BITS - 1);
         for (int i = 0; i < count; i++) begin
            upto = at + sim_pkg::TIME_BITS'($urandom_range(0, 2 * step));
            if ($urandom_range(15) == 0)
               upto = at - sim_pkg::TIME_BITS'($urandom_range(0, step));
            send_interval(at, upto, !cut_short && i == count - 1);
            at = at + sim_pkg::TIME_BITS'($urandom_range(0, 3 * step));
         end
      end
   endtask

   // Mostly well-formed lists, the rest cut-off lists and raw noise words.
   task automatic send_random_traffic(input int unsigned words);
      int unsigned goal;
      int unsigned pick;
      begin
         goal = words_sent + words;
         while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 75)
               send_random_list(1'b0);
            else if (pick < 85)
               send_random_list(1'b1);
            else
               send_interval(random_time(), random_time(), 1'($urandom_range(1)));
         end
      end
   endtask

   // Reset grid of 60: a lone word, a merge by extension, a break followed by
   // a flush from the same word, and a reversed interval.
   task automatic test_basic_lists();
      send_interval(40'd0, 40'd0, 1'b1);
      send_interval(40'd59, 40'd61, 1'b0);
      send_interval(40'd120, 40'd125, 1'b0);
      send_interval(40'd300, 40'd301, 1'b1);
      send_interval(40'd61, 40'd59, 1'b1);
   endtask

   // Field extremes: the top time snaps up past the start range.
   task automatic test_time_extremes();
      send_interval(TIME_TOP, TIME_TOP, 1'b1);
      send_interval(40'd0, TIME_TOP, 1'b0);
      send_interval(TIME_TOP - 40'd5, 40'd0, 1'b1);
      send_interval(40'd0, 40'd0, 1'b1);
   endtask

   // A start below the open start still merges when it overlaps, and the
   // open start is kept; a later gap then breaks the interval.
   task automatic test_unsorted_starts();
      send_interval(40'd600, 40'd800, 1'b0);
      send_interval(40'd100, 40'd200, 1'b0);
      send_interval(40'd900, 40'd900, 1'b0);
      send_interval(40'd10, 40'd20, 1'b1);
   endtask

   // Grid of zero (times pass unsnapped), a grid of 2^20, every
   // register bit set, and a grid of one.
   task automatic test_grid_settings();
      drain_results();
      program_grid(32'd0);
      send_interval(40'd123, 40'd457, 1'b0);
      send_interval(40'd457, 40'd500, 1'b1);
      drain_results();
      program_grid(32'd1048576);
      send_interval(TIME_TOP, TIME_TOP, 1'b1);
      send_interval(40'd1048575, 40'd1048577, 1'b1);
      drain_results();
      program_grid(32'h001F_FFFF);
      send_interval(random_time(), random_time(), 1'b1);
      send_interval(TIME_TOP, 40'd1, 1'b1);
      drain_results();
      program_grid(32'd1);
      send_interval(40'd5, 40'd9, 1'b0);
      send_interval(40'd10, 40'd12, 1'b1);
   endtask

   // Random phases, each with its own grid and idling pattern.
   task automatic test_random_lists();
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         unique case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               program_grid(32'd60);
            end
            1: begin
               send_idle_pct = 71;
               rsp_stall_pct = 0;
               program_grid(32'($urandom_range(2, 5000)));
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 71;
               program_grid(32'd1);
            end
            default: begin
               send_idle_pct = 11;
               rsp_stall_pct = 11;
               program_grid(32'($urandom_range(1, 1048576)));
            end
         endcase
         send_random_traffic(PHASE_WORDS);
      end
   endtask

   // The receiver holds off for a long stretch while words keep coming, so
   // the merger fills and stalls its input. The sender then waits for every
   // result before going on.
   task automatic test_backpressure();
      drain_results();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      program_grid(32'd60);
      hold_request = 1'b1;
      send_random_traffic(35);
      drain_results();
      send_random_traffic(35);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basic_lists();
      test_time_extremes();
      test_unsorted_starts();
      test_grid_settings();
      test_random_lists();
      test_backpressure();
      drain_results();

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Monitor: each result word taken is checked against the oldest prediction.
   always @(posedge clock) begin
      sim_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_merges.size() == 0) begin
            flag_error($sformatf("unexpected word start %0d end %0d ends_list %0b last_of_run %0b",
                                 rsp_data.merged_start, rsp_data.merged_end,
                                 rsp_data.ends_list, rsp_data.last_of_run));
         end else begin
            want = pending_merges.pop_front();
            if (rsp_data.merged_start !== want.merged_start
                  || rsp_data.merged_end !== want.merged_end
                  || rsp_data.ends_list !== want.ends_list
                  || rsp_data.last_of_run !== want.last_of_run)
               flag_error($sformatf({"expected start %0d end %0d ends_list %0b last_of_run %0b,",
                                     " got start %0d end %0d ends_list %0b last_of_run %0b"},
                                    want.merged_start, want.merged_end,
                                    want.ends_list, want.last_of_run,
                                    rsp_data.merged_start, rsp_data.merged_end,
                                    rsp_data.ends_list, rsp_data.last_of_run));
         end
      end
   end

endmodule
